// ===== sv/pioj_pkg.sv =====
// Shared types and constants for the padded interval overlap join.
// No dependencies; imported by pioj_ctrl, pioj_dp and the top level.
package pioj_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam logic [15:0] PAD_RESET = 16'd50;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_QUERY = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    typedef struct packed {
        logic [7:0]         chrom;
        logic signed [29:0] s;
        logic signed [29:0] e;
        logic [15:0]        tag;
    } t_entry;

    typedef struct packed {
        logic               last;
        logic [15:0]        stag;
        logic signed [29:0] se;
        logic signed [29:0] ss;
        logic               matched;
        logic [15:0]        qtag;
        logic signed [29:0] qe;
        logic signed [29:0] qs;
    } t_res;

    typedef struct packed {
        logic wr;
        logic clr;
        logic qry;
        logic scan;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic out_free;
    } t_sts;

endpackage

// ===== sv/pioj_ctrl.sv =====
// Sequencer for the interval join: decodes actions, runs the table scan and
// the final result. Depends on pioj_pkg.
module pioj_ctrl import pioj_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_action,
    input  t_sts       i_sts,
    output logic       o_ready,
    output t_cmd       o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_rdy, n_rdy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    case (i_action)
                        ACT_LOAD:  o_cmd.wr = 1'b1;
                        ACT_CLEAR: o_cmd.clr = 1'b1;
                        ACT_QUERY: begin
                            o_cmd.qry = 1'b1;
                            n_state   = ST_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.done) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        n_rdy = (n_state == ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rdy   <= 1'b1;
        end else begin
            r_state <= n_state;
            r_rdy   <= n_rdy;
        end
    end

    assign o_ready = r_rdy;

endmodule

// ===== sv/pioj_dp.sv =====
// Datapath for the interval join: pad register, subject table memory, scan
// read stage, overlap compare, pending match and output register. Uses pioj_pkg.
module pioj_dp import pioj_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic [7:0]  i_chrom,
    input  logic [27:0] i_start,
    input  logic [27:0] i_end,
    input  logic [15:0] i_tag,
    input  t_cmd        i_cmd,
    input  logic        i_out_ready,
    output t_sts        o_sts,
    output logic        o_out_valid,
    output t_res        o_out
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [15:0]        r_pad;
    t_entry             r_mem [TABLE_DEPTH];
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_addr;
    logic               r_rd_vld;
    t_entry             r_rd;
    logic [7:0]         r_qchrom;
    logic signed [29:0] r_qs;
    logic signed [29:0] r_qe;
    logic [15:0]        r_qtag;
    logic               r_pvld;
    t_entry             r_pend;
    logic               r_ovld;
    t_res               r_out;

    logic signed [29:0] pad_s;
    logic signed [29:0] pad_e;
    logic               full;
    logic               more;
    logic               hit;
    logic               out_free;
    logic               consume;
    logic               adv;
    logic               push;

    assign pad_s    = $signed({2'b00, i_start}) - $signed({14'd0, r_pad});
    assign pad_e    = $signed({2'b00, i_end}) + $signed({14'd0, r_pad});
    assign full     = (r_count == CW'(TABLE_DEPTH));
    assign more     = (r_addr != r_count);
    assign hit      = r_rd_vld && (r_rd.chrom == r_qchrom)
                      && !($signed(r_qs) > $signed(r_rd.e))
                      && !($signed(r_qe) < $signed(r_rd.s));
    assign out_free = !r_ovld || i_out_ready;
    assign consume  = r_rd_vld && (!hit || !r_pvld || out_free);
    assign adv      = i_cmd.scan && (!r_rd_vld || consume);
    assign push     = i_cmd.scan && hit && r_pvld && out_free;

    assign o_sts.done     = !r_rd_vld && !more;
    assign o_sts.out_free = out_free;

    // table storage and scan read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && !full) begin
            r_mem[r_count[AW-1:0]] <= '{chrom: i_chrom, s: pad_s, e: pad_e, tag: i_tag};
        end
        if (adv && more) begin
            r_rd <= r_mem[r_addr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad    <= PAD_RESET;
            r_count  <= '0;
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
            r_pvld   <= 1'b0;
            r_ovld   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_pad <= i_cfg_wdata;
            end
            if (i_cmd.clr) begin
                r_count <= '0;
            end else if (i_cmd.wr && !full) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.qry) begin
                r_addr   <= '0;
                r_rd_vld <= 1'b0;
            end else if (adv) begin
                r_rd_vld <= more;
                if (more) begin
                    r_addr <= r_addr + 1'b1;
                end
            end
            if (i_cmd.qry || i_cmd.fin) begin
                r_pvld <= 1'b0;
            end else if (i_cmd.scan && hit && consume) begin
                r_pvld <= 1'b1;
            end
            if (push || i_cmd.fin) begin
                r_ovld <= 1'b1;
            end else if (i_out_ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.qry) begin
            r_qchrom <= i_chrom;
            r_qs     <= pad_s;
            r_qe     <= pad_e;
            r_qtag   <= i_tag;
        end
        if (i_cmd.scan && hit && consume) begin
            r_pend <= r_rd;
        end
        if (push) begin
            r_out <= '{last: 1'b0, stag: r_pend.tag, se: r_pend.e, ss: r_pend.s,
                       matched: 1'b1, qtag: r_qtag, qe: r_qe, qs: r_qs};
        end else if (i_cmd.fin) begin
            r_out.last    <= 1'b1;
            r_out.matched <= r_pvld;
            r_out.stag    <= r_pvld ? r_pend.tag : 16'd0;
            r_out.se      <= r_pvld ? r_pend.e : 30'sd0;
            r_out.ss      <= r_pvld ? r_pend.s : 30'sd0;
            r_out.qtag    <= r_qtag;
            r_out.qe      <= r_qe;
            r_out.qs      <= r_qs;
        end
    end

    assign o_out_valid = r_ovld;
    assign o_out       = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld && !i_out_ready |=> r_ovld && $stable(r_out))
        else $error("stalled result changed");

    a_fin_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin |=> r_ovld && r_out.last)
        else $error("final result not marked last");

    a_push_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> r_pvld && out_free)
        else $error("match pushed without pending slot");

endmodule

// ===== sv/padded_interval_overlap_join_core.sv =====
// Padded interval overlap join top level: pioj_ctrl sequencer, pioj_dp datapath, pioj_pkg.
// Load, clear and ignored actions leave s_axis_tready high; a query drops it until the scan
// ends and its final result is registered. The scan reads one table entry a cycle unless
// output back-pressure holds it. Each match is held until the next is found so the final
// one can be marked; the final result carries tlast, and output stalls delay it.
// Synchronous active-low reset: pad to 50, table empty, no transfer pending.
module padded_interval_overlap_join_core import pioj_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [15:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // chrom_id[7:0], start_pos[35:8], end_pos[63:36], record_tag[79:64]
    input  logic [79:0]  s_axis_tdata,
    // action[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // query_start[29:0], query_end[59:30], query_tag[75:60],
    // subject_start[105:76], subject_end[135:106], subject_tag[151:136]
    output logic [151:0] m_axis_tdata,
    // matched[0]
    output logic         m_axis_tuser,
    output logic         m_axis_tlast
);

    t_cmd cmd;
    t_sts sts;
    t_res res;

    pioj_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_action (s_axis_tuser),
        .i_sts    (sts),
        .o_ready  (s_axis_tready),
        .o_cmd    (cmd)
    );

    pioj_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_chrom     (s_axis_tdata[7:0]),
        .i_start     (s_axis_tdata[35:8]),
        .i_end       (s_axis_tdata[63:36]),
        .i_tag       (s_axis_tdata[79:64]),
        .i_cmd       (cmd),
        .i_out_ready (m_axis_tready),
        .o_sts       (sts),
        .o_out_valid (m_axis_tvalid),
        .o_out       (res)
    );

    assign m_axis_tdata = {res.stag, res.se, res.ss, res.qtag, res.qe, res.qs};
    assign m_axis_tuser = res.matched;
    assign m_axis_tlast = res.last;

endmodule

// ===== test/padded_interval_overlap_join_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for padded_interval_overlap_join_core: directed rows, some with
// hand-written results, then random load/query/clear traffic under several pad
// settings, checked against a local join model. Depends on pioj_pkg and the core RTL.
module padded_interval_overlap_join_core_tb;
    import pioj_pkg::*;

    localparam int          JOIN_DEPTH = TABLE_DEPTH_DEF;
    localparam logic [1:0]  ACT_NONE   = 2'd3;
    localparam int          LIMIT      = 1_000_000;

    typedef struct packed {
        logic [29:0] q_lo;
        logic [29:0] q_hi;
        logic [15:0] q_tag;
        logic        hit;
        logic [29:0] s_lo;
        logic [29:0] s_hi;
        logic [15:0] s_tag;
        logic        last;
    } t_pair;

    typedef struct {
        logic [1:0]  act;
        logic [7:0]  chrom;
        logic [27:0] lo;
        logic [27:0] hi;
        logic [15:0] tag;
        bit          typed;
        t_pair       want;
    } t_interval_item;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [15:0]  i_cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // chrom_id, start_pos, end_pos, record_tag
    logic [79:0]  s_axis_tdata;
    // action
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // query_start, query_end, query_tag, subject_start, subject_end, subject_tag
    logic [151:0] m_axis_tdata;
    // matched
    logic         m_axis_tuser;
    logic         m_axis_tlast;

    // join model state
    int unsigned  pad_now;
    int unsigned  tbl_n;
    logic [7:0]   tbl_chrom [JOIN_DEPTH];
    longint       tbl_lo    [JOIN_DEPTH];
    longint       tbl_hi    [JOIN_DEPTH];
    logic [15:0]  tbl_tag   [JOIN_DEPTH];

    t_pair          pairs_due [$];
    t_interval_item directed_rows [$];
    int             bad_pairs;
    int             cycles;
    bit             src_calm;
    bit             snk_calm;

    padded_interval_overlap_join_core #(
        .TABLE_DEPTH(JOIN_DEPTH)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        while (cycles < LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic t_pair join_result(longint lo, longint hi, logic [15:0] tag, int j);
        t_pair p;
        p.q_lo  = lo[29:0];
        p.q_hi  = hi[29:0];
        p.q_tag = tag;
        p.hit   = (j >= 0);
        p.s_lo  = (j >= 0) ? tbl_lo[j][29:0] : 30'd0;
        p.s_hi  = (j >= 0) ? tbl_hi[j][29:0] : 30'd0;
        p.s_tag = (j >= 0) ? tbl_tag[j] : 16'd0;
        p.last  = 1'b0;
        return p;
    endfunction

    // Widens the item by the pad, then updates the table or queues the join pairs.
    function automatic void join_interval(input t_interval_item r);
        longint lo;
        longint hi;
        t_pair  held;
        bit     have;
        lo   = longint'(r.lo) - longint'(pad_now);
        hi   = longint'(r.hi) + longint'(pad_now);
        have = 1'b0;
        case (r.act)
            ACT_LOAD: begin
                if (tbl_n < JOIN_DEPTH) begin
                    tbl_chrom[tbl_n] = r.chrom;
                    tbl_lo[tbl_n]    = lo;
                    tbl_hi[tbl_n]    = hi;
                    tbl_tag[tbl_n]   = r.tag;
                    tbl_n++;
                end
            end
            ACT_CLEAR: begin
                tbl_n = 0;
            end
            ACT_QUERY: begin
                for (int j = 0; j < tbl_n; j++) begin
                    if (tbl_chrom[j] == r.chrom && !(lo > tbl_hi[j] || hi < tbl_lo[j])) begin
                        if (have) pairs_due.push_back(held);
                        held = join_result(lo, hi, r.tag, j);
                        have = 1'b1;
                    end
                end
                if (!have) held = join_result(lo, hi, r.tag, -1);
                held.last = 1'b1;
                pairs_due.push_back(held);
            end
            default: ;
        endcase
    endfunction

    task automatic add_row(input logic [1:0] act, input logic [7:0] chrom,
                           input logic [27:0] lo, input logic [27:0] hi,
                           input logic [15:0] tag);
        t_interval_item r;
        r.act   = act;
        r.chrom = chrom;
        r.lo    = lo;
        r.hi    = hi;
        r.tag   = tag;
        r.typed = 1'b0;
        r.want  = '0;
        directed_rows.push_back(r);
    endtask

    // Query row whose single result is written out by hand.
    task automatic add_chk(input logic [7:0] chrom, input logic [27:0] lo,
                           input logic [27:0] hi, input logic [15:0] tag,
                           input int qs, input int qe, input bit hit,
                           input int ss, input int se, input logic [15:0] stag);
        t_interval_item r;
        r.act        = ACT_QUERY;
        r.chrom      = chrom;
        r.lo         = lo;
        r.hi         = hi;
        r.tag        = tag;
        r.typed      = 1'b1;
        r.want.q_lo  = qs[29:0];
        r.want.q_hi  = qe[29:0];
        r.want.q_tag = tag;
        r.want.hit   = hit;
        r.want.s_lo  = ss[29:0];
        r.want.s_hi  = se[29:0];
        r.want.s_tag = stag;
        r.want.last  = 1'b1;
        directed_rows.push_back(r);
    endtask

    function automatic t_interval_item rand_interval(input int unsigned base);
        t_interval_item r;
        int unsigned    pick;
        int unsigned    k;
        pick = $urandom_range(0, 99);
        if (pick < 6)       r.act = ACT_CLEAR;
        else if (pick < 48) r.act = ACT_LOAD;
        else if (pick < 96) r.act = ACT_QUERY;
        else                r.act = ACT_NONE;
        r.chrom = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, 3));
        k = $urandom_range(0, 19);
        if (k == 0) begin
            r.lo = 28'($urandom);
            r.hi = 28'($urandom);
        end else if (k == 1) begin
            r.lo = 28'(base + $urandom_range(1000, 4000));
            r.hi = 28'(r.lo - $urandom_range(1, 900));
        end else begin
            r.lo = 28'(base + $urandom_range(0, 4000));
            r.hi = 28'(r.lo + $urandom_range(0, 1500));
        end
        r.tag   = 16'($urandom);
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    // Entered and left at a falling edge; tvalid stays high for the caller to lower.
    task automatic push_item(input t_interval_item r);
        int gap;
        if ($urandom_range(0, 15) == 0) src_calm = ~src_calm;
        if ($urandom_range(0, 15) == 0) snk_calm = ~snk_calm;
        gap = src_calm ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {r.tag, r.hi, r.lo, r.chrom};
        s_axis_tuser  <= r.act;
        do @(posedge i_clk); while (!s_axis_tready);
        if (r.typed) pairs_due.push_back(r.want);
        else         join_interval(r);
        @(negedge i_clk);
    endtask

    task automatic run_mix(input int n);
        int unsigned base;
        base = $urandom_range(0, 28'hFFFFFFF);
        repeat (n) push_item(rand_interval(base));
    endtask

    task automatic set_pad(input logic [15:0] v);
        s_axis_tvalid <= 1'b0;
        while (pairs_due.size() != 0) @(negedge i_clk);
        // a trailing load or clear gives no transfer to wait for
        repeat (100) @(negedge i_clk);
        i_cfg_wdata <= v;
        i_cfg_we    <= 1'b1;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        pad_now = v;
    endtask

    task automatic note_bad(input string what, input longint want, input longint got);
        if (bad_pairs < 10)
            $display("mismatch on %s at cycle %0d: expected %0h, got %0h",
                     what, cycles, want, got);
        bad_pairs++;
    endtask

    // result side: random stalls, compare each transfer with the oldest pending pair
    initial begin
        int    stall;
        t_pair got;
        t_pair want;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = snk_calm ? 0 : $urandom_range(0, 7);
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            got.q_lo  = m_axis_tdata[29:0];
            got.q_hi  = m_axis_tdata[59:30];
            got.q_tag = m_axis_tdata[75:60];
            got.s_lo  = m_axis_tdata[105:76];
            got.s_hi  = m_axis_tdata[135:106];
            got.s_tag = m_axis_tdata[151:136];
            got.hit   = m_axis_tuser;
            got.last  = m_axis_tlast;
            if (pairs_due.size() == 0) begin
                note_bad("unexpected transfer", 0, 0);
            end else begin
                want = pairs_due.pop_front();
                if (got.q_lo !== want.q_lo)   note_bad("query_start", want.q_lo, got.q_lo);
                if (got.q_hi !== want.q_hi)   note_bad("query_end", want.q_hi, got.q_hi);
                if (got.q_tag !== want.q_tag) note_bad("query_tag", want.q_tag, got.q_tag);
                if (got.hit !== want.hit)     note_bad("matched", want.hit, got.hit);
                if (got.s_lo !== want.s_lo)   note_bad("subject_start", want.s_lo, got.s_lo);
                if (got.s_hi !== want.s_hi)   note_bad("subject_end", want.s_hi, got.s_hi);
                if (got.s_tag !== want.s_tag) note_bad("subject_tag", want.s_tag, got.s_tag);
                if (got.last !== want.last)   note_bad("last_of_run", want.last, got.last);
            end
            @(negedge i_clk);
        end
    end

    initial begin
        t_interval_item r;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = 16'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ACT_NONE;
        pad_now       = PAD_RESET;
        tbl_n         = 0;
        bad_pairs     = 0;
        cycles        = 0;
        src_calm      = 1'b0;
        snk_calm      = 1'b0;

        // pad 50 from reset throughout the directed rows
        add_chk(8'd0, 28'd100, 28'd200, 16'h0001, 50, 250, 1'b0, 0, 0, 16'h0);
        add_chk(8'hFF, 28'd0, 28'hFFFFFFF, 16'hFFFF, -50, 268435505, 1'b0, 0, 0, 16'h0);
        add_row(ACT_LOAD, 8'd5, 28'd1000, 28'd2000, 16'hA5A5);
        add_chk(8'd5, 28'd2100, 28'd2200, 16'h0002, 2050, 2250, 1'b1, 950, 2050, 16'hA5A5);
        add_chk(8'd5, 28'd2101, 28'd2300, 16'h0003, 2051, 2350, 1'b0, 0, 0, 16'h0);
        add_chk(8'd6, 28'd1000, 28'd2000, 16'h0004, 950, 2050, 1'b0, 0, 0, 16'h0);
        add_row(ACT_LOAD, 8'd5, 28'd0, 28'd0, 16'h0000);
        add_row(ACT_LOAD, 8'hFF, 28'hFFFFFFF, 28'hFFFFFFF, 16'hFFFF);
        add_row(ACT_QUERY, 8'd5, 28'd0, 28'd1000, 16'h0005);
        add_chk(8'hFF, 28'hFFFFFFF, 28'hFFFFFFF, 16'h0006, 268435405, 268435505,
                1'b1, 268435405, 268435505, 16'hFFFF);
        add_row(ACT_LOAD, 8'd7, 28'd5000, 28'd1000, 16'h0007);
        add_chk(8'd7, 28'd2000, 28'd3000, 16'h0008, 1950, 3050, 1'b0, 0, 0, 16'h0);
        add_row(ACT_QUERY, 8'd7, 28'd1000, 28'd5000, 16'h0009);
        add_row(ACT_NONE, 8'd5, 28'd1000, 28'd2000, 16'h000A);
        add_row(ACT_QUERY, 8'd5, 28'd1000, 28'd2000, 16'h000B);
        add_row(ACT_CLEAR, 8'd0, 28'd0, 28'd0, 16'h0000);
        add_chk(8'd5, 28'd1000, 28'd2000, 16'h000C, 950, 2050, 1'b0, 0, 0, 16'h0);
        add_row(ACT_LOAD, 8'd1, 28'd300, 28'd400, 16'h1234);
        add_row(ACT_LOAD, 8'd1, 28'd350, 28'd360, 16'h4321);
        add_row(ACT_QUERY, 8'd1, 28'd0, 28'hFFFFFFF, 16'h0F0F);
        add_chk(8'd1, 28'd500, 28'd100, 16'h000D, 450, 150, 1'b0, 0, 0, 16'h0);
        add_row(ACT_CLEAR, 8'd0, 28'd0, 28'd0, 16'h0000);

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) push_item(directed_rows[i]);

        set_pad(16'd0);
        run_mix(20);

        // widest pad, table filled past capacity, then queries hitting most entries
        set_pad(16'hFFFF);
        add_row(ACT_CLEAR, 8'd0, 28'd0, 28'd0, 16'h0000);
        push_item(directed_rows[$]);
        repeat (JOIN_DEPTH + 2) begin
            r = rand_interval(32'd1000);
            r.act   = ACT_LOAD;
            r.chrom = ($urandom_range(0, 7) == 0) ? 8'd1 : 8'd0;
            push_item(r);
        end
        repeat (10) begin
            r = rand_interval(32'd1000);
            r.act   = ACT_QUERY;
            r.chrom = 8'($urandom_range(0, 1));
            push_item(r);
        end

        set_pad(16'($urandom_range(1, 65534)));
        run_mix(20);

        set_pad(16'($urandom_range(0, 300)));
        run_mix(20);

        s_axis_tvalid <= 1'b0;
        while (pairs_due.size() != 0) @(negedge i_clk);
        repeat (100) @(posedge i_clk);
        if (bad_pairs == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== padded_interval_overlap_join_core.f =====
sv/pioj_pkg.sv
sv/pioj_ctrl.sv
sv/pioj_dp.sv
sv/padded_interval_overlap_join_core.sv
test/padded_interval_overlap_join_core_tb.sv
